[sv/gda_pkg.sv]
`timescale 1ns / 1ps
// shared widths, types and calendar helpers for the date advance unit
package gda_pkg;

   localparam int YearWidth    = 14;
   localparam int MonthWidth   = 4;
   localparam int DayWidth     = 5;
   localparam int CountWidth   = 16;
   localparam int WeekdayWidth = 3;
   localparam int StatusWidth  = 2;
   localparam int SumWidth     = 17;   // day sum and weekday sum
   localparam int ModWidth     = 9;    // year modulo 400
   localparam int DoyWidth     = 9;    // day of year
   localparam int QuotWidth    = 6;    // year / 400
   localparam int ProdWidth    = YearWidth + 16;
   localparam int RecipShift   = 24;
   localparam int QueueDepth   = 2;
   localparam int PtrWidth     = $clog2(QueueDepth);
   localparam int CountBits    = $clog2(QueueDepth + 1);

   localparam logic [YearWidth-1:0]  MaxYear  = YearWidth'(9999);
   localparam logic [15:0]           Recip400 = 16'd41944;   // ceil(2^24 / 400)
   localparam logic [ModWidth-1:0]   LastMod  = ModWidth'(399);
   localparam logic [MonthWidth-1:0] LastMonth = MonthWidth'(12);

   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_DATE = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_STEP,
      BACK_FINISH
   } back_state_type;

   // one classified item between front and back
   typedef struct packed {
      logic                    valid_date;
      logic [YearWidth-1:0]    start_year;
      logic [MonthWidth-1:0]   start_month;
      logic [DayWidth-1:0]     start_day;
      logic [SumWidth-1:0]     day_sum;
      logic [ModWidth-1:0]     year_mod;
      logic [SumWidth-1:0]     week_sum;
   } entry_type;

   function automatic logic leap_of_mod(input logic [ModWidth-1:0] ymod);
      leap_of_mod = (ymod[1:0] == 2'b00) && (ymod != ModWidth'(100)) &&
                    (ymod != ModWidth'(200)) && (ymod != ModWidth'(300));
   endfunction

   function automatic logic [DayWidth-1:0] month_days(input logic leap,
                                                      input logic [MonthWidth-1:0] month);
      logic [DayWidth-1:0] len;
      unique case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DayWidth'(31);
         4'd4, 4'd6, 4'd9, 4'd11:                    len = DayWidth'(30);
         4'd2:  len = leap ? DayWidth'(29) : DayWidth'(28);
         default: len = '0;
      endcase
      month_days = len;
   endfunction

   function automatic logic [DoyWidth-1:0] days_before(input logic leap,
                                                      input logic [MonthWidth-1:0] month);
      logic [DoyWidth-1:0] cum;
      unique case (month)
         4'd1:  cum = DoyWidth'(0);
         4'd2:  cum = DoyWidth'(31);
         4'd3:  cum = DoyWidth'(59);
         4'd4:  cum = DoyWidth'(90);
         4'd5:  cum = DoyWidth'(120);
         4'd6:  cum = DoyWidth'(151);
         4'd7:  cum = DoyWidth'(181);
         4'd8:  cum = DoyWidth'(212);
         4'd9:  cum = DoyWidth'(243);
         4'd10: cum = DoyWidth'(273);
         4'd11: cum = DoyWidth'(304);
         4'd12: cum = DoyWidth'(334);
         default: cum = '0;
      endcase
      if (leap && (month > MonthWidth'(2))) begin
         cum = cum + DoyWidth'(1);
      end
      days_before = cum;
   endfunction

   // modulo 7 by folding octal digits, since 8 is 1 mod 7
   function automatic logic [WeekdayWidth-1:0] mod7(input logic [SumWidth-1:0] value);
      logic [5:0] fold1;
      logic [3:0] fold2;
      fold1 = 6'(value[2:0]) + 6'(value[5:3]) + 6'(value[8:6]) + 6'(value[11:9]) +
              6'(value[14:12]) + 6'(value[16:15]);
      fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
      if (fold2 >= 4'd7) begin
         fold2 = fold2 - 4'd7;
      end
      mod7 = fold2[WeekdayWidth-1:0];
   endfunction

endpackage

[sv/gda_front.sv]
`timescale 1ns / 1ps
// front end: takes the request beat, checks the date and prepares the sums
module gda_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [gda_pkg::YearWidth-1:0]     start_year,
   input  logic [gda_pkg::MonthWidth-1:0]    start_month,
   input  logic [gda_pkg::DayWidth-1:0]      start_day,
   input  logic [gda_pkg::CountWidth-1:0]    days_to_add,
   input  logic                              push,
   output logic                              full,
   output logic                              q_push,
   output gda_pkg::entry_type                q_data,
   input  logic                              q_full
);
   import gda_pkg::*;

   logic                     s1_valid_ff, s1_valid_in;
   logic [YearWidth-1:0]     year_ff;
   logic [MonthWidth-1:0]    month_ff;
   logic [DayWidth-1:0]      day_ff;
   logic [CountWidth-1:0]    count_ff;
   logic [QuotWidth-1:0]     quot_ff, quot_in;
   logic                     accept;
   logic [YearWidth-1:0]     prev_in;
   logic [ProdWidth-1:0]     prod;

   logic [YearWidth-1:0]     prev_year;
   logic [YearWidth-1:0]     quot_x400;
   logic [YearWidth-1:0]     rem_wide;
   logic [ModWidth-1:0]      prev_mod;
   logic [ModWidth-1:0]      year_mod;
   logic                     leap;
   logic [1:0]               centuries;
   logic [7:0]               prev_div100;
   logic [DoyWidth-1:0]      doy;
   logic                     date_ok;

   assign full   = s1_valid_ff && q_full;
   assign accept = push && !full;
   assign q_push = s1_valid_ff && !q_full;

   // years before the start year divided by 400, reciprocal multiply
   always_comb begin
      prev_in = start_year - YearWidth'(1);
      prod    = ProdWidth'(prev_in) * ProdWidth'(Recip400);
      quot_in = prod[RecipShift +: QuotWidth];
      s1_valid_in = accept || (s1_valid_ff && q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         year_ff  <= start_year;
         month_ff <= start_month;
         day_ff   <= start_day;
         count_ff <= days_to_add;
         quot_ff  <= quot_in;
      end
   end

   // classification and weekday sum
   always_comb begin
      prev_year   = year_ff - YearWidth'(1);
      quot_x400   = (YearWidth'(quot_ff) << 8) + (YearWidth'(quot_ff) << 7) +
                    (YearWidth'(quot_ff) << 4);
      rem_wide    = prev_year - quot_x400;
      prev_mod    = rem_wide[ModWidth-1:0];
      year_mod    = (prev_mod == LastMod) ? '0 : prev_mod + ModWidth'(1);
      leap        = leap_of_mod(year_mod);
      if (prev_mod >= ModWidth'(300)) begin
         centuries = 2'd3;
      end else if (prev_mod >= ModWidth'(200)) begin
         centuries = 2'd2;
      end else if (prev_mod >= ModWidth'(100)) begin
         centuries = 2'd1;
      end else begin
         centuries = 2'd0;
      end
      prev_div100 = {quot_ff, centuries};
      doy         = days_before(leap, month_ff) + DoyWidth'(day_ff);
      date_ok     = (year_ff != '0) && (year_ff <= MaxYear) &&
                    (month_ff != '0) && (month_ff <= LastMonth) &&
                    (day_ff != '0) && (day_ff <= month_days(leap, month_ff));

      q_data.valid_date  = date_ok;
      q_data.start_year  = year_ff;
      q_data.start_month = month_ff;
      q_data.start_day   = day_ff;
      q_data.day_sum     = SumWidth'(day_ff) + SumWidth'(count_ff);
      q_data.year_mod    = year_mod;
      q_data.week_sum    = SumWidth'(prev_year) + SumWidth'(prev_year >> 2) -
                           SumWidth'(prev_div100) + SumWidth'(quot_ff) +
                           SumWidth'(doy) + SumWidth'(count_ff);
   end

endmodule

[sv/gda_queue.sv]
`timescale 1ns / 1ps
// short queue of classified items between front and back
module gda_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gda_pkg::entry_type  push_data,
   output logic                full,
   input  logic                pop,
   output gda_pkg::entry_type  pop_data,
   output logic                empty
);
   import gda_pkg::*;

   entry_type              slots_ff [QueueDepth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0]   fill_ff, fill_in;
   logic                   do_push, do_pop;

   assign full     = (fill_ff == CountBits'(QueueDepth));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CountBits'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/gda_back.sv]
`timescale 1ns / 1ps
// back end: steps whole months off the day count and holds the response
module gda_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   output logic                              q_pop,
   input  gda_pkg::entry_type                q_data,
   output logic [gda_pkg::YearWidth-1:0]     result_year,
   output logic [gda_pkg::MonthWidth-1:0]    result_month,
   output logic [gda_pkg::DayWidth-1:0]      result_day,
   output logic [gda_pkg::WeekdayWidth-1:0]  weekday,
   output logic [gda_pkg::StatusWidth-1:0]   status,
   output logic                              empty,
   input  logic                              pop
);
   import gda_pkg::*;

   back_state_type           state_ff, state_in;

   logic [YearWidth-1:0]     start_year_ff;
   logic [MonthWidth-1:0]    start_month_ff;
   logic [DayWidth-1:0]      start_day_ff;
   logic [YearWidth-1:0]     y_ff, y_in;
   logic [MonthWidth-1:0]    m_ff, m_in;
   logic [SumWidth-1:0]      d_ff, d_in;
   logic [ModWidth-1:0]      ymod_ff, ymod_in;
   logic [SumWidth-1:0]      wsum_ff;
   status_type               stat_ff, stat_in;

   logic [YearWidth-1:0]     rsp_year_ff, rsp_year_in;
   logic [MonthWidth-1:0]    rsp_month_ff, rsp_month_in;
   logic [DayWidth-1:0]      rsp_day_ff, rsp_day_in;
   logic [WeekdayWidth-1:0]  rsp_wday_ff, rsp_wday_in;
   logic [StatusWidth-1:0]   rsp_stat_ff, rsp_stat_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [DayWidth-1:0]      mlen;
   logic                     more;
   logic                     ovf;
   logic                     out_free;
   logic                     load_out;

   assign mlen     = month_days(leap_of_mod(ymod_ff), m_ff);
   assign more     = d_ff > SumWidth'(mlen);
   assign ovf      = more && (m_ff == LastMonth) && (y_ff == MaxYear);
   assign out_free = !rsp_valid_ff || pop;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!q_empty) begin
               state_in = q_data.valid_date ? BACK_STEP : BACK_FINISH;
            end
         end
         BACK_STEP: begin
            if (!more || ovf) begin
               state_in = BACK_FINISH;
            end
         end
         BACK_FINISH: begin
            if (out_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop    = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         BACK_IDLE:   q_pop    = !q_empty;
         BACK_STEP:   ;
         BACK_FINISH: load_out = out_free;
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // month stepping
   always_comb begin
      y_in    = y_ff;
      m_in    = m_ff;
      d_in    = d_ff;
      ymod_in = ymod_ff;
      stat_in = stat_ff;
      if (q_pop) begin
         y_in    = q_data.start_year;
         m_in    = q_data.start_month;
         d_in    = q_data.day_sum;
         ymod_in = q_data.year_mod;
         stat_in = q_data.valid_date ? STATUS_OK : STATUS_BAD_DATE;
      end else if ((state_ff == BACK_STEP) && more) begin
         if (ovf) begin
            stat_in = STATUS_OVERFLOW;
         end else begin
            d_in = d_ff - SumWidth'(mlen);
            if (m_ff == LastMonth) begin
               m_in    = MonthWidth'(1);
               y_in    = y_ff + YearWidth'(1);
               ymod_in = (ymod_ff == LastMod) ? '0 : ymod_ff + ModWidth'(1);
            end else begin
               m_in = m_ff + MonthWidth'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      y_ff    <= y_in;
      m_ff    <= m_in;
      d_ff    <= d_in;
      ymod_ff <= ymod_in;
      stat_ff <= stat_in;
      if (q_pop) begin
         start_year_ff  <= q_data.start_year;
         start_month_ff <= q_data.start_month;
         start_day_ff   <= q_data.start_day;
         wsum_ff        <= q_data.week_sum;
      end
   end

   // response register
   always_comb begin
      rsp_year_in  = rsp_year_ff;
      rsp_month_in = rsp_month_ff;
      rsp_day_in   = rsp_day_ff;
      rsp_wday_in  = rsp_wday_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_stat_in  = stat_ff;
         if (stat_ff == STATUS_OK) begin
            rsp_year_in  = y_ff;
            rsp_month_in = m_ff;
            rsp_day_in   = d_ff[DayWidth-1:0];
            rsp_wday_in  = mod7(wsum_ff);
         end else begin
            rsp_year_in  = start_year_ff;
            rsp_month_in = start_month_ff;
            rsp_day_in   = start_day_ff;
            rsp_wday_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_year_ff  <= rsp_year_in;
      rsp_month_ff <= rsp_month_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_wday_ff  <= rsp_wday_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   assign result_year  = rsp_year_ff;
   assign result_month = rsp_month_ff;
   assign result_day   = rsp_day_ff;
   assign weekday      = rsp_wday_ff;
   assign status       = rsp_stat_ff;
   assign empty        = !rsp_valid_ff;

   // stepping only ever sees a checked, in-range date
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_STEP) |->
         (m_ff != '0) && (m_ff <= LastMonth) && (y_ff != '0) && (y_ff <= MaxYear))
      else $error("month or year out of range while stepping");

   // a good response has a real day and a weekday below seven
   a_ok_response: assert property (@(posedge clock) disable iff (reset)
      (load_out && (stat_ff == STATUS_OK)) |=>
         (rsp_day_ff != '0) && (rsp_wday_ff < WeekdayWidth'(7)))
      else $error("bad day or weekday on good response");

   // error responses echo the start date with weekday zero
   a_error_echo: assert property (@(posedge clock) disable iff (reset)
      (load_out && (stat_ff != STATUS_OK)) |=>
         (rsp_wday_ff == '0) && (rsp_year_ff == $past(start_year_ff)) &&
         (rsp_day_ff == $past(start_day_ff)))
      else $error("error response does not echo the start date");

endmodule

[sv/gregorian_date_add_days_unit.sv]
`timescale 1ns / 1ps
// top level of the gregorian date advance and weekday unit
// Each request beat carries a proleptic Gregorian date and a day count; the
// response beat gives the date that many days later, its weekday (0 Sunday to
// 6 Saturday) and a status: 0 ok, 1 invalid start date, 2 result past year
// 9999, where both error cases echo the start date with weekday 0. The front
// end checks the date, works out the year modulo 400 and the weekday sum in
// the cycle after the beat is taken and hands the item through a two-entry
// queue to the back end.
// The back end moves the date forward one month per cycle, so the time an
// item spends there grows with the months crossed; an invalid date skips
// the stepping. The back end handles one item at a time; the front end and
// the queue keep taking request beats while it works, and a finished response
// waits in its own register so the next item can start before the response
// is popped. Throughput is therefore set by the month-stepping loop in the
// back end.
module gregorian_date_add_days_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [gda_pkg::YearWidth-1:0]     req_start_year,
   input  logic [gda_pkg::MonthWidth-1:0]    req_start_month,
   input  logic [gda_pkg::DayWidth-1:0]      req_start_day,
   input  logic [gda_pkg::CountWidth-1:0]    req_days_to_add,
   input  logic                              push,
   output logic                              full,
   output logic [gda_pkg::YearWidth-1:0]     rsp_result_year,
   output logic [gda_pkg::MonthWidth-1:0]    rsp_result_month,
   output logic [gda_pkg::DayWidth-1:0]      rsp_result_day,
   output logic [gda_pkg::WeekdayWidth-1:0]  rsp_weekday,
   output logic [gda_pkg::StatusWidth-1:0]   rsp_status,
   output logic                              empty,
   input  logic                              pop
);
   import gda_pkg::*;

   // front to queue
   logic        fq_push;
   logic        fq_full;
   entry_type   fq_data;

   // queue to back
   logic        qb_pop;
   logic        qb_empty;
   entry_type   qb_data;

   // request side: date check and sums
   gda_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start_year  (req_start_year),
      .start_month (req_start_month),
      .start_day   (req_start_day),
      .days_to_add (req_days_to_add),
      .push        (push),
      .full        (full),
      .q_push      (fq_push),
      .q_data      (fq_data),
      .q_full      (fq_full)
   );

   // decouples the checking from the month stepping
   gda_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_data),
      .full      (fq_full),
      .pop       (qb_pop),
      .pop_data  (qb_data),
      .empty     (qb_empty)
   );

   // month stepping and response register
   gda_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (qb_empty),
      .q_pop        (qb_pop),
      .q_data       (qb_data),
      .result_year  (rsp_result_year),
      .result_month (rsp_result_month),
      .result_day   (rsp_result_day),
      .weekday      (rsp_weekday),
      .status       (rsp_status),
      .empty        (empty),
      .pop          (pop)
   );

endmodule

[sim/gregorian_date_add_days_unit_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the gregorian date advance and weekday unit
module gregorian_date_add_days_unit_tb;
   import gda_pkg::*;

   // generous ceiling: every item at the longest month walk plus both worst stalls, times four
   localparam int CycleLimit = 3_000_000;
   // quiet cycles after the last beat, about one full month walk
   localparam int TailCycles = 2300;
   localparam int RandomItems = 246;
   localparam int MaxWait = 17;

   // one pending request beat, with the idle gap to leave before it
   typedef struct {
      logic [YearWidth-1:0]  year;
      logic [MonthWidth-1:0] month;
      logic [DayWidth-1:0]   day;
      logic [CountWidth-1:0] days;
      int                    gap;
      bit                    drain;   // hold off until every answer is back
   } date_req_type;

   // one predicted response beat
   typedef struct {
      logic [YearWidth-1:0]    year;
      logic [MonthWidth-1:0]   month;
      logic [DayWidth-1:0]     day;
      logic [WeekdayWidth-1:0] weekday;
      status_type              status;
   } date_answer_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic [YearWidth-1:0]    req_start_year = '0;
   logic [MonthWidth-1:0]   req_start_month = '0;
   logic [DayWidth-1:0]     req_start_day = '0;
   logic [CountWidth-1:0]   req_days_to_add = '0;
   logic                    push = 1'b0;
   logic                    full;
   logic [YearWidth-1:0]    rsp_result_year;
   logic [MonthWidth-1:0]   rsp_result_month;
   logic [DayWidth-1:0]     rsp_result_day;
   logic [WeekdayWidth-1:0] rsp_weekday;
   logic [StatusWidth-1:0]  rsp_status;
   logic                    empty;
   logic                    pop = 1'b0;

   date_req_type    date_req_q[$];   // beats still to send
   date_answer_type answer_q[$];     // answers owed by the unit, oldest first
   int              fail_count = 0;
   int              items_built = 0;
   int              results_seen = 0;
   int              cycle_count = 0;

   gregorian_date_add_days_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_start_year   (req_start_year),
      .req_start_month  (req_start_month),
      .req_start_day    (req_start_day),
      .req_days_to_add  (req_days_to_add),
      .push             (push),
      .full             (full),
      .rsp_result_year  (rsp_result_year),
      .rsp_result_month (rsp_result_month),
      .rsp_result_day   (rsp_result_day),
      .rsp_weekday      (rsp_weekday),
      .rsp_status       (rsp_status),
      .empty            (empty),
      .pop              (pop)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- calendar

   function automatic bit leap_year(int y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   // zero for a month that does not exist, so any day fails the range check
   function automatic int month_length(int y, int m);
      case (m)
         2:             return leap_year(y) ? 29 : 28;
         4, 6, 9, 11:   return 30;
         1, 3, 5, 7, 8, 10, 12: return 31;
         default:       return 0;
      endcase
   endfunction

   // expected answer for one request beat
   function automatic date_answer_type advance_date(int y0, int m0, int d0, int n);
      date_answer_type ans;
      int y;
      int m;
      int d;
      int prior;
      int doy;
      ans.year    = YearWidth'(y0);
      ans.month   = MonthWidth'(m0);
      ans.day     = DayWidth'(d0);
      ans.weekday = '0;
      ans.status  = STATUS_OK;
      // bad start date: echo it, weekday zero
      if (y0 < 1 || y0 > 9999 || d0 < 1 || d0 > month_length(y0, m0)) begin
         ans.status = STATUS_BAD_DATE;
         return ans;
      end
      y = y0;
      m = m0;
      d = d0 + n;
      // peel whole months off the running day count
      while (d > month_length(y, m)) begin
         d = d - month_length(y, m);
         if (m == 12) begin
            m = 1;
            y = y + 1;
         end else begin
            m = m + 1;
         end
         // walked past the last representable year: echo the start date
         if (y > 9999) begin
            ans.status = STATUS_OVERFLOW;
            return ans;
         end
      end
      // weekday from days before the year plus day of year, sunday is zero
      prior = y - 1;
      doy = d;
      for (int k = 1; k < m; k++) begin
         doy = doy + month_length(y, k);
      end
      ans.year    = YearWidth'(y);
      ans.month   = MonthWidth'(m);
      ans.day     = DayWidth'(d);
      ans.weekday = WeekdayWidth'((prior + prior / 4 - prior / 100 + prior / 400 + doy) % 7);
      return ans;
   endfunction

   // ---------------------------------------------------------------- stimulus

   // idle cycles before a beat; calm stretches send back to back
   function automatic int draw_wait(bit calm);
      if (calm || $urandom_range(0, 3) == 0) begin
         return 0;
      end
      return $urandom_range(0, MaxWait);
   endfunction

   task automatic add_item(int y, int m, int d, int n, bit drain);
      date_req_type item;
      item.year  = YearWidth'(y);
      item.month = MonthWidth'(m);
      item.day   = DayWidth'(d);
      item.days  = CountWidth'(n);
      item.gap   = draw_wait(((items_built / 30) % 3) == 2);
      item.drain = drain;
      date_req_q.push_back(item);
      items_built++;
   endtask

   // mostly well-formed dates, with a spread of counts and some junk
   task automatic add_random_item(bit drain);
      int pick;
      int y;
      int m;
      int d;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         // raw bits, toggles every input bit
         add_item($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                  $urandom_range(0, 65535), drain);
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2: y = $urandom_range(1, 30);
            3, 4:    y = $urandom_range(9800, 9999);
            default: y = $urandom_range(1, 9999);
         endcase
         m = $urandom_range(1, 12);
         d = $urandom_range(1, month_length(y, m));
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: n = $urandom_range(0, 40);
            10, 11, 12, 13, 14:           n = $urandom_range(0, 1000);
            15, 16:                       n = $urandom_range(60000, 65535);
            default:                      n = $urandom_range(0, 65535);
         endcase
         if (pick < 15) begin
            // nearly valid: day just past the month end, or a month beyond december
            if ($urandom_range(0, 1) == 0) begin
               d = $urandom_range(month_length(y, m) + 1, 31);
            end else begin
               m = $urandom_range(13, 15);
            end
         end
         add_item(y, m, d, n, drain);
      end
   endtask

   // ---------------------------------------------------------------- driver

   int  idle_left = 0;
   bit  gap_loaded = 1'b0;
   bit  push_next;

   // push stays up until the beat is taken; one assignment per edge
   always @(posedge clock) begin
      if (reset) begin
         push            <= 1'b0;
         req_start_year  <= '0;
         req_start_month <= '0;
         req_start_day   <= '0;
         req_days_to_add <= '0;
         idle_left  = 0;
         gap_loaded = 1'b0;
      end else begin
         push_next = push && full;
         if (push && !full) begin
            // beat taken: owe its answer
            answer_q.push_back(advance_date(req_start_year, req_start_month, req_start_day,
                                            req_days_to_add));
            void'(date_req_q.pop_front());
         end
         if (!push_next && date_req_q.size() > 0) begin
            if (!gap_loaded) begin
               idle_left  = date_req_q[0].gap;
               gap_loaded = 1'b1;
            end
            if (date_req_q[0].drain && answer_q.size() != 0) begin
               // pressure point: let the unit run completely dry first
            end else if (idle_left > 0) begin
               idle_left--;
            end else begin
               push_next       = 1'b1;
               gap_loaded      = 1'b0;
               req_start_year  <= date_req_q[0].year;
               req_start_month <= date_req_q[0].month;
               req_start_day   <= date_req_q[0].day;
               req_days_to_add <= date_req_q[0].days;
            end
         end
         push <= push_next;
      end
   end

   // ---------------------------------------------------------------- monitor

   int              stall_left = 0;
   date_answer_type want;

   task automatic compare_field(string label, int want_v, int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want_v, got_v);
         fail_count++;
      end
   endtask

   // every taken response beat is matched against the oldest owed answer
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         stall_left = 0;
      end else begin
         if (pop && !empty) begin
            if (answer_q.size() == 0) begin
               $display("%0t: response beat with no answer owed, actual %0d-%0d-%0d",
                        $time, rsp_result_year, rsp_result_month, rsp_result_day);
               fail_count++;
            end else begin
               want = answer_q.pop_front();
               compare_field("result_year", int'(want.year), int'(rsp_result_year));
               compare_field("result_month", int'(want.month), int'(rsp_result_month));
               compare_field("result_day", int'(want.day), int'(rsp_result_day));
               compare_field("weekday", int'(want.weekday), int'(rsp_weekday));
               compare_field("status", int'(want.status), int'(rsp_status));
            end
            results_seen++;
            stall_left = draw_wait(((results_seen / 25) % 3) == 1);
         end
         if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timed out with %0d answers still owed", $time, answer_q.size());
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      // directed corners first
      add_item(2000, 1, 1, 0, 1'b0);          // zero days, saturday
      add_item(1, 1, 1, 0, 1'b0);             // first representable day, monday
      add_item(1, 1, 1, 65535, 1'b0);         // longest walk from the very start
      add_item(9999, 12, 31, 0, 1'b0);        // last representable day
      add_item(9999, 12, 31, 1, 1'b0);        // one day past the end overflows
      add_item(9999, 1, 1, 364, 1'b0);        // lands exactly on the last day
      add_item(9999, 1, 1, 365, 1'b0);        // just over
      add_item(9900, 6, 15, 65535, 1'b0);     // long count runs off the end
      add_item(2000, 2, 28, 1, 1'b0);         // leap century, into february 29th
      add_item(1900, 2, 28, 1, 1'b0);         // common century, straight to march
      add_item(2024, 2, 29, 0, 1'b0);         // leap day as a start date
      add_item(2000, 2, 29, 365, 1'b0);       // across a leap february
      add_item(2399, 12, 31, 1, 1'b0);        // year roll into a 400 year
      add_item(2021, 1, 31, 31, 1'b0);        // month end chained past short february
      add_item(2023, 2, 29, 0, 1'b0);         // leap day in a common year
      add_item(1900, 2, 29, 5, 1'b0);         // leap day in a common century
      add_item(0, 1, 1, 10, 1'b0);            // year zero
      add_item(10000, 1, 1, 0, 1'b0);         // year just past the range
      add_item(16383, 15, 31, 65535, 1'b0);   // every input bit high
      add_item(0, 0, 0, 0, 1'b0);             // every input bit low
      add_item(2020, 0, 10, 3, 1'b0);         // month zero
      add_item(2020, 13, 10, 3, 1'b0);        // month thirteen
      add_item(2020, 5, 0, 3, 1'b0);          // day zero
      add_item(2021, 4, 31, 3, 1'b0);         // 31st of a 30 day month
      // random bulk; the first beat and the middle one each wait until every owed answer is back
      for (int k = 0; k < RandomItems; k++) begin
         add_random_item(k == 0 || k == RandomItems / 2);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (date_req_q.size() != 0 || push) begin
         @(posedge clock);
      end
      while (answer_q.size() != 0) begin
         @(posedge clock);
      end
      // room for any stray beat still inside the month walk
      repeat (TailCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
